>>> hw/rtl/ssk_pkg.sv
// Shared constants and control/status types for the Stirling number block.
package ssk_pkg;

  // Largest set size whose row the cell array can hold
  localparam int MAX_N = 32;

  localparam int SIZE_W   = 6;
  localparam int COUNT_W  = 64;
  localparam int CELL_IDX_W = (MAX_N > 1) ? $clog2(MAX_N) : 1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;     // take a new query and clear the cells
    logic step;     // build the next row
    logic capture;  // latch the answer into the result register
  } ssk_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic trivial;  // answer is known without building rows
    logic last;     // the row being built is row n
  } ssk_sts_t;

endpackage

>>> hw/rtl/ssk_ctrl.sv
// Controller state machine for the Stirling number block.
module ssk_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  ssk_pkg::ssk_sts_t sts_i,
  output ssk_pkg::ssk_cmd_t cmd_o,
  output logic              busy_o,
  output logic              done_o
);
  import ssk_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StSetup,
    StBuild,
    StFinish
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  // Decode commands from the current state
  always_comb begin
    cmd_o.load    = (state_q == StIdle) && start_i;
    cmd_o.step    = (state_q == StBuild);
    cmd_o.capture = (state_q == StFinish);
  end

  // Choose the next state
  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (start_i) state_d = StSetup;
      end
      StSetup: begin
        state_d = sts_i.trivial ? StFinish : StBuild;
      end
      StBuild: begin
        if (sts_i.last) state_d = StFinish;
      end
      StFinish: begin
        state_d = StIdle;
        done_d  = 1'b1;
      end
      default: state_d = StIdle;
    endcase
  end

  // Hold state and the result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != StIdle);
  assign done_o = done_q;

endmodule

>>> hw/rtl/ssk_datapath.sv
// Row cells, query registers and result register for the Stirling number block.
module ssk_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ssk_pkg::ssk_cmd_t            cmd_i,
  input  logic [ssk_pkg::SIZE_W-1:0]   set_size_i,
  input  logic [ssk_pkg::SIZE_W-1:0]   subset_count_i,
  output ssk_pkg::ssk_sts_t            sts_o,
  output logic [ssk_pkg::COUNT_W-1:0]  partition_count_o
);
  import ssk_pkg::*;

  // Cell j-1 holds S(row, j) for j = 1..MAX_N; S(row, 0) is implied
  logic [COUNT_W-1:0] cell_q [MAX_N];
  logic [COUNT_W-1:0] cell_d [MAX_N];
  logic [SIZE_W-1:0]  n_q, k_q;
  logic [SIZE_W-1:0]  row_q;
  logic [COUNT_W-1:0] result_q, result_d;
  logic [SIZE_W-1:0]  row_next;
  logic [CELL_IDX_W-1:0] k_less;
  logic               both_zero;

  assign row_next  = row_q + SIZE_W'(1);
  assign k_less    = k_q[CELL_IDX_W-1:0] - CELL_IDX_W'(1);
  assign both_zero = (n_q == '0) && (k_q == '0);

  // Flag queries answered without a build, and the final row
  always_comb begin
    sts_o.trivial = (n_q == '0) || (k_q == '0) || (k_q > n_q) || (int'(n_q) > MAX_N);
    sts_o.last    = (row_next == n_q);
  end

  // Update every cell of the row in parallel: S(i,j) = j*S(i-1,j) + S(i-1,j-1)
  always_comb begin
    for (int j = 0; j < MAX_N; j++) begin
      if (j == 0) begin
        cell_d[j] = COUNT_W'(1) * cell_q[j] + ((row_q == '0) ? COUNT_W'(1) : '0);
      end else begin
        cell_d[j] = COUNT_W'(j + 1) * cell_q[j] + cell_q[j-1];
      end
    end
  end

  // Clear at load, advance at each step
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < MAX_N; j++) begin
      if (cmd_i.load) begin
        cell_q[j] <= '0;
      end else if (cmd_i.step) begin
        cell_q[j] <= cell_d[j];
      end
    end
  end

  // Hold the query and the row counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else if (cmd_i.load) begin
      row_q <= '0;
    end else if (cmd_i.step) begin
      row_q <= row_next;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q <= set_size_i;
      k_q <= subset_count_i;
    end
  end

  // Pick the answer
  always_comb begin
    if (sts_o.trivial) begin
      result_d = both_zero ? COUNT_W'(1) : '0;
    end else begin
      result_d = cell_q[k_less];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      result_q <= result_d;
    end
  end

  assign partition_count_o = result_q;

endmodule

>>> hw/rtl/stirling_second_kind.sv
// Top level of the Stirling number of the second kind block.
// Give a query (n, k) with start_i while busy_o is low; the block returns
// S(n,k) modulo 2^64 on partition_count_o for one cycle, marked by done_o,
// and cannot be held off, so the receiver must take it then. A query passes
// from accept through the setup state, one build step per row of the parallel
// cell array and the capture state to the result beat; a query answered
// directly (n or k zero, k > n, n above 32) skips the build steps. A new
// query may be given in the cycle that the result is shown.
module stirling_second_kind (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [ssk_pkg::SIZE_W-1:0]   set_size_i,
  input  logic [ssk_pkg::SIZE_W-1:0]   subset_count_i,
  output logic                         busy_o,
  output logic                         done_o,
  output logic [ssk_pkg::COUNT_W-1:0]  partition_count_o
);
  import ssk_pkg::*;

  ssk_cmd_t cmd;
  ssk_sts_t sts;

  // Sequence the query
  ssk_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  // Build rows and hold the answer
  ssk_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .set_size_i        (set_size_i),
    .subset_count_i    (subset_count_i),
    .sts_o             (sts),
    .partition_count_o (partition_count_o)
  );

endmodule

>>> hw/rtl/ssk_checker.sv
// Port-level assertions for the Stirling number block, bound to the top level.
module ssk_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start_i,
  input logic [ssk_pkg::SIZE_W-1:0]   set_size_i,
  input logic [ssk_pkg::SIZE_W-1:0]   subset_count_i,
  input logic                         busy_o,
  input logic                         done_o,
  input logic [ssk_pkg::COUNT_W-1:0]  partition_count_o
);
  import ssk_pkg::*;

  // An accepted beat makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted query did not raise busy");

  // The result beat comes exactly when busy drops
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("busy dropped without a result beat");

  // A result beat only follows a busy cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o && $past(busy_o))
    else $error("result beat outside a query");

  // S(0,0) is one, answered without a build
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (set_size_i == '0) && (subset_count_i == '0)
    |=> ##2 done_o && (partition_count_o == COUNT_W'(1)))
    else $error("S(0,0) not returned as one");

endmodule

bind stirling_second_kind ssk_checker u_ssk_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .start_i           (start_i),
  .set_size_i        (set_size_i),
  .subset_count_i    (subset_count_i),
  .busy_o            (busy_o),
  .done_o            (done_o),
  .partition_count_o (partition_count_o)
);

>>> tb/ssk_checker.sv
// Scoreboard for the Stirling number block: predicts each query and checks every result beat.
module ssk_scoreboard (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [ssk_pkg::SIZE_W-1:0]   set_size_i,
  input  logic [ssk_pkg::SIZE_W-1:0]   subset_count_i,
  input  logic                         busy_i,
  input  logic                         done_i,
  input  logic [ssk_pkg::COUNT_W-1:0]  partition_count_i,
  output int                           errors_o,
  output int                           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [ssk_pkg::SIZE_W-1:0]  set_size;
    logic [ssk_pkg::SIZE_W-1:0]  subset_count;
    logic [ssk_pkg::COUNT_W-1:0] partition_count;
  } query_answer_t;

  query_answer_t answers_q[$];
  int            mismatches = 0;

  assign errors_o = mismatches;

  // Build the partition table row by row, cells updated from the top index down.
  function automatic logic [ssk_pkg::COUNT_W-1:0] partition_count_of(
    input logic [ssk_pkg::SIZE_W-1:0] objects,
    input logic [ssk_pkg::SIZE_W-1:0] subsets
  );
    logic [ssk_pkg::COUNT_W-1:0] row [0:ssk_pkg::MAX_N];
    int                          r;
    int                          c;
    if (objects == 0 && subsets == 0) return 64'd1;
    if (objects == 0 || subsets == 0 || subsets > objects || objects > ssk_pkg::MAX_N)
      return 64'd0;
    for (c = 0; c <= ssk_pkg::MAX_N; c++) row[c] = 64'd0;
    row[0] = 64'd1;
    for (r = 1; r <= objects; r++) begin
      for (c = r; c >= 1; c--) row[c] = row[c] * 64'(c) + row[c-1];
      row[0] = 64'd0;
    end
    return row[subsets];
  endfunction

  // Retire the oldest answer on each result beat, then queue the answer for a new query.
  always @(posedge clk_i or negedge rst_ni) begin
    query_answer_t oldest;
    query_answer_t fresh;
    if (!rst_ni) begin
      answers_q.delete();
      pending_o <= 0;
    end else begin
      if (done_i) begin
        if (answers_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: result beat with no query waiting, got %0d", $realtime,
                     partition_count_i);
        end else begin
          oldest = answers_q.pop_front();
          if (partition_count_i !== oldest.partition_count) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("%0t: S(%0d,%0d) expected %0d got %0d", $realtime,
                       oldest.set_size, oldest.subset_count,
                       oldest.partition_count, partition_count_i);
          end
        end
      end
      if (start_i && !busy_i) begin
        fresh.set_size        = set_size_i;
        fresh.subset_count    = subset_count_i;
        fresh.partition_count = partition_count_of(set_size_i, subset_count_i);
        answers_q.push_back(fresh);
      end
      pending_o <= answers_q.size();
    end
  end

endmodule

>>> tb/tb_top.sv
// Top of the Stirling number testbench: clock, reset, query stimulus and the verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ssk_pkg::*;

  localparam int RANDOM_QUERIES = 1880;
  localparam int WATCHDOG_LIMIT = 400;
  localparam int DRAIN_CYCLES   = 40;
  localparam int DIRECTED_COUNT = 20;

  // Corner queries: zeros, k above n, n above the row store, full-size rows that wrap
  localparam int DIRECTED_N [DIRECTED_COUNT] =
    '{0, 0, 5, 1, 2, 3, 32, 32, 32, 32, 33, 63, 63, 0, 63, 26, 32, 1, 17, 40};
  localparam int DIRECTED_K [DIRECTED_COUNT] =
    '{0, 5, 0, 1, 1, 5, 32, 1, 16, 17, 1, 63, 0, 63, 1, 13, 2, 0, 9, 3};

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic [SIZE_W-1:0]   set_size_i;
  logic [SIZE_W-1:0]   subset_count_i;
  logic                busy_o;
  logic                done_o;
  logic [COUNT_W-1:0]  partition_count_o;

  int mismatch_count;
  int pending_count;
  int stall_cycles = 0;

  stirling_second_kind dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .set_size_i        (set_size_i),
    .subset_count_i    (subset_count_i),
    .busy_o            (busy_o),
    .done_o            (done_o),
    .partition_count_o (partition_count_o)
  );

  ssk_scoreboard scoreboard (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .set_size_i        (set_size_i),
    .subset_count_i    (subset_count_i),
    .busy_i            (busy_o),
    .done_i            (done_o),
    .partition_count_i (partition_count_o),
    .errors_o          (mismatch_count),
    .pending_o         (pending_count)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Abort when no query and no result beat moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("stirling_second_kind regression: fail");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Hold start low for gap cycles, then offer one query until the block takes it.
  task automatic send_query(input logic [SIZE_W-1:0] objects,
                            input logic [SIZE_W-1:0] subsets, input int gap);
    repeat (gap) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
    @(negedge clk_i);
    start_i        <= 1'b1;
    set_size_i     <= objects;
    subset_count_i <= subsets;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Drop start and hold off until every queued answer has come back.
  task automatic wait_drained();
    do begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end while (pending_count != 0);
  endtask

  function automatic int pick_gap(input bit quiet);
    if (quiet || $urandom_range(99) >= 38) return 0;
    return $urandom_range(1, 3);
  endfunction

  initial begin
    logic [SIZE_W-1:0] objects;
    logic [SIZE_W-1:0] subsets;
    bit                quiet;
    start_i        = 1'b0;
    set_size_i     = '0;
    subset_count_i = '0;
    rst_ni         = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int d = 0; d < DIRECTED_COUNT; d++)
      send_query(SIZE_W'(DIRECTED_N[d]), SIZE_W'(DIRECTED_K[d]), pick_gap(1'b0));
    wait_drained();

    // Mostly valid queries, with some full-range noise to hit every input bit.
    for (int i = 0; i < RANDOM_QUERIES; i++) begin
      quiet = (i >= 800 && i < 1100);
      if (i == 400 || i == 1500) wait_drained();
      if ($urandom_range(99) < 85) begin
        objects = SIZE_W'($urandom_range(1, MAX_N));
        subsets = SIZE_W'($urandom_range(1, objects));
      end else begin
        objects = SIZE_W'($urandom_range(0, 63));
        subsets = SIZE_W'($urandom_range(0, 63));
      end
      send_query(objects, subsets, pick_gap(quiet));
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0)
      $display("stirling_second_kind regression: pass");
    else
      $display("stirling_second_kind regression: fail");
    $finish;
  end

endmodule
